### hw/rtl/rtpp_pkg.sv
// Shared types, constants and helpers for the rotating target panel position block.
// Used by the controller, the datapath and the top level; depends on nothing else.
package rtpp_pkg;

    localparam int TWO_PI_Q16   = 411775;
    localparam int TP           = TWO_PI_Q16;
    localparam int MAX_PANELS_D = 8;
    localparam int CORDIC_D     = 16;
    localparam int RESULT_LIMIT = 8;
    localparam int ATAN_N       = 24;
    localparam int MOD_TOP      = 20;
    localparam logic [3:0] PANEL_RESET = 4'd4;

    localparam logic signed [35:0] PI_Q30          = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30     = 36'sd1686629713;
    localparam logic signed [35:0] THREE_HALF_Q30  = 36'sd5059889139;
    localparam logic signed [35:0] TWO_PI_Q30      = 36'sd6746521600;
    localparam logic signed [33:0] GAIN_Q30        = 34'sd652032874;

    localparam logic signed [35:0] ATAN_Q30 [ATAN_N] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043836, 36'sd133525159,
        36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
        36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288,
        36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
        36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
        36'sd1024, 36'sd512, 36'sd256, 36'sd128
    };

    // Row is panel count minus one, column is the panel number.
    localparam logic [21:0] ANGLE_TAB [8][8] = '{
        '{22'(0), 22'(TP*1/1), 22'(TP*2/1), 22'(TP*3/1),
          22'(TP*4/1), 22'(TP*5/1), 22'(TP*6/1), 22'(TP*7/1)},
        '{22'(0), 22'(TP*1/2), 22'(TP*2/2), 22'(TP*3/2),
          22'(TP*4/2), 22'(TP*5/2), 22'(TP*6/2), 22'(TP*7/2)},
        '{22'(0), 22'(TP*1/3), 22'(TP*2/3), 22'(TP*3/3),
          22'(TP*4/3), 22'(TP*5/3), 22'(TP*6/3), 22'(TP*7/3)},
        '{22'(0), 22'(TP*1/4), 22'(TP*2/4), 22'(TP*3/4),
          22'(TP*4/4), 22'(TP*5/4), 22'(TP*6/4), 22'(TP*7/4)},
        '{22'(0), 22'(TP*1/5), 22'(TP*2/5), 22'(TP*3/5),
          22'(TP*4/5), 22'(TP*5/5), 22'(TP*6/5), 22'(TP*7/5)},
        '{22'(0), 22'(TP*1/6), 22'(TP*2/6), 22'(TP*3/6),
          22'(TP*4/6), 22'(TP*5/6), 22'(TP*6/6), 22'(TP*7/6)},
        '{22'(0), 22'(TP*1/7), 22'(TP*2/7), 22'(TP*3/7),
          22'(TP*4/7), 22'(TP*5/7), 22'(TP*6/7), 22'(TP*7/7)},
        '{22'(0), 22'(TP*1/8), 22'(TP*2/8), 22'(TP*3/8),
          22'(TP*4/8), 22'(TP*5/8), 22'(TP*6/8), 22'(TP*7/8)}
    };

    typedef struct packed {
        logic       load;
        logic       pred_mul;
        logic       pred_add;
        logic [1:0] sel;
        logic       mod_step;
        logic [4:0] mod_bit;
        logic       ang;
        logic       rot;
        logic [4:0] rot_i;
        logic       prod;
        logic       emit;
        logic [2:0] panel;
        logic [2:0] n_m1;
        logic       last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

### hw/rtl/rtpp_ctrl.sv
// Controller state machine for the rotating target panel position block.
// Holds the panel count register and sequences the datapath; uses rtpp_pkg.
module rtpp_ctrl import rtpp_pkg::*; #(
    parameter int MAX_PANELS   = MAX_PANELS_D,
    parameter int CORDIC_STEPS = CORDIC_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_ANG  = 3'd4;
    localparam logic [2:0] S_ROT  = 3'd5;
    localparam logic [2:0] S_PROD = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    localparam int LIM = (MAX_PANELS < RESULT_LIMIT) ? MAX_PANELS : RESULT_LIMIT;

    logic [2:0] r_state, n_state;
    logic [3:0] r_count;
    logic [1:0] r_sel, n_sel;
    logic [4:0] r_mod_bit, n_mod_bit;
    logic [4:0] r_rot_i, n_rot_i;
    logic [2:0] r_panel, n_panel;
    logic [2:0] r_n_m1, n_n_m1;
    logic [3:0] cnt_eff;

    always_comb begin
        cnt_eff = r_count;
        if (cnt_eff == 4'd0) begin
            cnt_eff = 4'd1;
        end
        if (cnt_eff > 4'(LIM)) begin
            cnt_eff = 4'(LIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= PANEL_RESET;
            r_sel     <= '0;
            r_mod_bit <= '0;
            r_rot_i   <= '0;
            r_panel   <= '0;
            r_n_m1    <= '0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_mod_bit <= n_mod_bit;
            r_rot_i   <= n_rot_i;
            r_panel   <= n_panel;
            r_n_m1    <= n_n_m1;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_mod_bit = r_mod_bit;
        n_rot_i   = r_rot_i;
        n_panel   = r_panel;
        n_n_m1    = r_n_m1;
        o_in_ready = 1'b0;
        o_cmd = '0;
        o_cmd.sel     = r_sel;
        o_cmd.mod_bit = r_mod_bit;
        o_cmd.rot_i   = r_rot_i;
        o_cmd.panel   = r_panel;
        o_cmd.n_m1    = r_n_m1;
        o_cmd.last    = (r_panel == r_n_m1);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_sel   = '0;
                    n_n_m1  = 3'(cnt_eff - 4'd1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.pred_mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.pred_add = 1'b1;
                if (r_sel == 2'd3) begin
                    n_mod_bit = 5'(MOD_TOP);
                    n_state   = S_MOD;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_mod_bit == 5'd0) begin
                    n_panel = '0;
                    n_state = S_ANG;
                end else begin
                    n_mod_bit = r_mod_bit - 5'd1;
                end
            end
            S_ANG: begin
                o_cmd.ang = 1'b1;
                n_rot_i = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                if (r_rot_i == 5'(CORDIC_STEPS - 1)) begin
                    n_state = S_PROD;
                end else begin
                    n_rot_i = r_rot_i + 5'd1;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    if (r_panel == r_n_m1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_panel = r_panel + 3'd1;
                        n_state = S_ANG;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/rtpp_dp.sv
// Datapath for the rotating target panel position block: prediction, angle
// reduction, CORDIC rotation and the output register. Uses rtpp_pkg.
module rtpp_dp import rtpp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [327:0] i_in_data,
    input  t_dp_cmd      i_cmd,
    output t_dp_sts      o_sts,
    output logic [95:0]  o_tdata,
    output logic [2:0]   o_tuser,
    output logic         o_tlast,
    output logic         o_tvalid,
    input  logic         i_tready
);

    logic signed [31:0] r_cx, r_cy, r_cz, r_vx, r_vy, r_vz, r_yaw, r_rate;
    logic [19:0]        r_dt;
    logic [16:0]        r_re, r_ro;
    logic signed [16:0] r_h;
    logic signed [52:0] r_prod;
    logic [39:0]        r_mod;
    logic signed [33:0] r_x, r_y;
    logic signed [35:0] r_z;
    logic               r_neg;
    logic signed [51:0] r_px, r_py;
    logic [95:0]        r_tdata;
    logic [2:0]         r_tuser;
    logic               r_tlast, r_tvalid;

    logic signed [31:0] opnd;
    logic signed [52:0] rsum;
    logic signed [36:0] rnd;
    logic [39:0]        cand;
    logic [22:0]        a_sum;
    logic [18:0]        a_red;
    logic signed [35:0] z0;
    logic signed [33:0] xs, ys, co, si;
    logic [16:0]        rad;
    logic signed [51:0] ex, ey;
    logic signed [21:0] rx, ry;
    logic signed [17:0] dz;

    always_comb begin
        case (i_cmd.sel)
            2'd0: opnd = r_vx;
            2'd1: opnd = r_vy;
            2'd2: opnd = r_vz;
            default: opnd = r_rate;
        endcase
        rsum  = r_prod + 53'sd32768;
        rnd   = rsum[52:16];
        cand  = 40'(TWO_PI_Q16) << i_cmd.mod_bit;
        a_sum = {4'd0, r_mod[18:0]} + {1'b0, ANGLE_TAB[i_cmd.n_m1][i_cmd.panel]};
        a_red = (a_sum >= 23'(TWO_PI_Q16)) ? 19'(a_sum - 23'(TWO_PI_Q16)) : a_sum[18:0];
        z0    = $signed({3'd0, a_red, 14'd0});
        xs    = r_x >>> i_cmd.rot_i;
        ys    = r_y >>> i_cmd.rot_i;
        co    = r_neg ? -r_x : r_x;
        si    = r_neg ? -r_y : r_y;
        rad   = i_cmd.panel[0] ? r_ro : r_re;
        ex    = r_px + 52'sd536870912;
        ey    = r_py + 52'sd536870912;
        rx    = ex[51:30];
        ry    = ey[51:30];
        dz    = i_cmd.panel[0] ? 18'(r_h) : -18'(r_h);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx   <= i_in_data[31:0];
            r_cy   <= i_in_data[63:32];
            r_cz   <= i_in_data[95:64];
            r_vx   <= i_in_data[127:96];
            r_vy   <= i_in_data[159:128];
            r_vz   <= i_in_data[191:160];
            r_yaw  <= i_in_data[223:192];
            r_rate <= i_in_data[255:224];
            r_dt   <= i_in_data[275:256];
            r_re   <= i_in_data[292:276];
            r_ro   <= i_in_data[309:293];
            r_h    <= i_in_data[326:310];
        end
        if (i_cmd.pred_mul) begin
            r_prod <= 53'($signed({1'b0, r_dt})) * 53'(opnd);
        end
        if (i_cmd.pred_add) begin
            case (i_cmd.sel)
                2'd0: r_cx <= sat32(40'(r_cx) + 40'(rnd));
                2'd1: r_cy <= sat32(40'(r_cy) + 40'(rnd));
                2'd2: r_cz <= sat32(40'(r_cz) + 40'(rnd));
                default: r_mod <= 40'(40'(r_yaw) + 40'(rnd) + (40'(TWO_PI_Q16) << MOD_TOP));
            endcase
        end
        if (i_cmd.mod_step && (r_mod >= cand)) begin
            r_mod <= r_mod - cand;
        end
        if (i_cmd.ang) begin
            r_x <= GAIN_Q30;
            r_y <= '0;
            if ((z0 > HALF_PI_Q30) && (z0 < THREE_HALF_Q30)) begin
                r_z   <= z0 - PI_Q30;
                r_neg <= 1'b1;
            end else if (z0 >= THREE_HALF_Q30) begin
                r_z   <= z0 - TWO_PI_Q30;
                r_neg <= 1'b0;
            end else begin
                r_z   <= z0;
                r_neg <= 1'b0;
            end
        end
        if (i_cmd.rot) begin
            if (r_z >= 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ATAN_Q30[i_cmd.rot_i];
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ATAN_Q30[i_cmd.rot_i];
            end
        end
        if (i_cmd.prod) begin
            r_px <= 52'($signed({1'b0, rad})) * 52'(co);
            r_py <= 52'($signed({1'b0, rad})) * 52'(si);
        end
        if (i_cmd.emit) begin
            r_tdata[31:0]  <= sat32(40'(r_cx) + 40'(rx));
            r_tdata[63:32] <= sat32(40'(r_cy) + 40'(ry));
            r_tdata[95:64] <= sat32(40'(r_cz) + 40'(dz));
            r_tuser        <= i_cmd.panel;
            r_tlast        <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_tvalid <= 1'b1;
        end else if (i_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    assign o_sts.out_full = r_tvalid && !i_tready;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;
    assign o_tvalid = r_tvalid;

endmodule

### hw/rtl/rotating_target_panel_positions.sv
// Sequence: prediction and yaw reduction, then per panel an angle set-up, the CORDIC loop
// (one step a cycle), a product and the output write; output stalls hold the sequence.
// Requests are handled one at a time: a new one is taken only after the last panel is written.
// Reset is synchronous and active low; it empties the output and sets the panel count to four.
module rotating_target_panel_positions import rtpp_pkg::*; #(
    parameter int MAX_PANELS   = MAX_PANELS_D,
    parameter int CORDIC_STEPS = CORDIC_D
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, center_z, velocity_x, velocity_y, velocity_z, yaw_angle,
    // yaw_rate, predict_time, radius_even, radius_odd, height_offset, one pad bit.
    input  logic [327:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // panel_x, panel_y, panel_z.
    output logic [95:0]  m_axis_tdata,
    // panel_index.
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rtpp_ctrl #(
        .MAX_PANELS  (MAX_PANELS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rtpp_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_data(s_axis_tdata),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready)
    );

endmodule

### hw/rtl/rtpp_checker.sv
// Port-level checks for the rotating target panel position block.
// Bound to rotating_target_panel_positions; needs no package.
module rtpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Output data changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken again right after a request.");

    a_prediction_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##8 !s_axis_tready)
        else $error("Input taken before the prediction finished.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule

bind rotating_target_panel_positions rtpp_checker u_rtpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

### sim/tb_top.sv
// Self-checking testbench for rotating_target_panel_positions: drives target descriptions
// with random pacing and checks every panel position against an in-bench predictor.
// Depends on rtpp_pkg and the RTL top level only.
module tb_top;
    import rtpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] cx, cy, cz, vx, vy, vz, yaw, rate;
        logic [19:0]        dt;
        logic [16:0]        r_even, r_odd;
        logic signed [16:0] h;
    } t_target;

    typedef struct packed {
        logic signed [31:0] px, py, pz;
        logic [2:0]         idx;
        logic               last;
    } t_panel;

    typedef struct {
        t_target tgt;
        logic    has_exp;
        t_panel  exp0;
    } t_row;

    localparam longint GAIN = 652032874;
    localparam longint HALF_PI = 1686629713;
    localparam longint PI_W = 64'sd3373259426;
    localparam longint THREE_HALF = 64'sd5059889139;
    localparam longint LIMIT = 400000;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_cfg_we = 0;
    logic [3:0]    i_cfg_wdata = 0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [327:0]  s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [95:0]   m_axis_tdata;
    logic [2:0]    m_axis_tuser;
    logic          m_axis_tlast;

    rotating_target_panel_positions u_top (.*);

    t_panel  expected_panels[$];
    logic [3:0] cur_count;
    int      mismatches = 0;
    longint  cycles = 0;
    bit      hold_off = 0;
    bit      quiet = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic longint asr_l(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void rotate_unit(longint a16, output longint co, output longint si);
        longint z, x, y, nx, ny;
        bit neg;
        z = a16 * 16384;
        x = GAIN;
        y = 0;
        neg = 0;
        if (z > HALF_PI && z < THREE_HALF) begin
            z -= PI_W;
            neg = 1;
        end else if (z >= THREE_HALF) begin
            z -= longint'(TWO_PI_Q16) * 16384;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - asr_l(y, i);
                ny = y + asr_l(x, i);
                z -= longint'(ATAN_Q30[i]);
            end else begin
                nx = x + asr_l(y, i);
                ny = y - asr_l(x, i);
                z += longint'(ATAN_Q30[i]);
            end
            x = nx;
            y = ny;
        end
        co = neg ? -x : x;
        si = neg ? -y : y;
    endfunction

    function automatic void predict_panels(t_target t);
        longint dt, cx, cy, cz, yaw, n, r, dz, a, co, si;
        t_panel p;
        dt = t.dt;
        n = cur_count;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        cx = clip32(longint'(t.cx) + rnd_shift(dt * longint'(t.vx), 16));
        cy = clip32(longint'(t.cy) + rnd_shift(dt * longint'(t.vy), 16));
        cz = clip32(longint'(t.cz) + rnd_shift(dt * longint'(t.vz), 16));
        yaw = longint'(t.yaw) + rnd_shift(dt * longint'(t.rate), 16);
        yaw = yaw % TWO_PI_Q16;
        if (yaw < 0) yaw += TWO_PI_Q16;
        for (longint i = 0; i < n; i++) begin
            r = i[0] ? longint'(t.r_odd) : longint'(t.r_even);
            dz = i[0] ? longint'(t.h) : -longint'(t.h);
            a = yaw + (i * TWO_PI_Q16) / n;
            if (a >= TWO_PI_Q16) a -= TWO_PI_Q16;
            rotate_unit(a, co, si);
            p.px = 32'(clip32(cx + rnd_shift(r * co, 30)));
            p.py = 32'(clip32(cy + rnd_shift(r * si, 30)));
            p.pz = 32'(clip32(cz + dz));
            p.idx = i[2:0];
            p.last = (i == n - 1);
            expected_panels = {expected_panels, p};
        end
    endfunction

    // Receiver: random stall pattern, plus a long hold-off or an always-ready quiet mode when requested.
    initial begin
        int pat;
        pat = 0;
        forever begin
            @(posedge i_clk);
            pat = pat + 1;
            if (hold_off) m_axis_tready <= 0;
            else if (quiet) m_axis_tready <= 1;
            else m_axis_tready <= ((pat % 7) < 5) ? ($urandom_range(0, 3) != 0) : 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_panel got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.px = m_axis_tdata[31:0];
            got.py = m_axis_tdata[63:32];
            got.pz = m_axis_tdata[95:64];
            got.idx = m_axis_tuser;
            got.last = m_axis_tlast;
            if (expected_panels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected panel %p", got);
            end else begin
                want = expected_panels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("panel mismatch: exp %p got %p", want, got);
                end
            end
        end
    end

    function automatic t_target random_target();
        t_target t;
        t = '0;
        t.cx = $urandom;
        t.cy = $urandom;
        t.cz = $urandom;
        t.vx = $urandom;
        t.vy = $urandom;
        t.vz = $urandom;
        t.yaw = $urandom;
        t.rate = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            t.cx = $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21);
            t.cy = $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21);
            t.vx = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
            t.rate = $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
        end
        t.dt = ($urandom_range(0, 5) == 0) ? 20'd0 : 20'($urandom);
        t.r_even = 17'($urandom);
        t.r_odd = 17'($urandom);
        t.h = 17'($urandom);
        return t;
    endfunction

    task automatic send_target(t_target t);
        s_axis_tdata <= {1'b0, t.h, t.r_odd, t.r_even, t.dt, t.rate, t.yaw,
                         t.vz, t.vy, t.vx, t.cz, t.cy, t.cx};
        s_axis_tvalid <= 1;
        predict_panels(t);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        while (expected_panels.size() != 0) @(posedge i_clk);
        repeat (350) @(posedge i_clk);
    endtask

    task automatic set_count(logic [3:0] v);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        cur_count = v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    t_row rows[$];

    task automatic add_row(t_target t, logic has, t_panel e);
        t_row rw;
        rw.tgt = t;
        rw.has_exp = has;
        rw.exp0 = e;
        rows = {rows, rw};
    endtask

    initial begin
        t_target t;
        t_panel e;
        int burst;
        logic [3:0] counts[6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6};

        cur_count = PANEL_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // At yaw zero with no prediction, panel zero sits at center + radius on x;
        // the CORDIC residue leaves y one step below zero.
        t = '0;
        t.r_even = 17'd65536;
        e = '0;
        e.px = 32'sd65536;
        e.py = -32'sd1;
        add_row(t, 1, e);
        t = '0;
        t.cx = 32'sh7FFFFFFF;
        t.cz = 32'sh80000000;
        t.r_even = 17'h1FFFF;
        t.r_odd = 17'h1FFFF;
        t.h = 17'sh10000;
        e = '0;
        e.px = 32'sh7FFFFFFF;
        e.py = -32'sd2;
        e.pz = 32'sh80010000;
        add_row(t, 1, e);
        t = '0;
        t.cx = 32'sh80000000;
        t.cy = 32'sh7FFFFFFF;
        t.vx = 32'sh80000000;
        t.vy = 32'sh7FFFFFFF;
        t.vz = 32'sh7FFFFFFF;
        t.yaw = 32'sh80000000;
        t.rate = 32'sh7FFFFFFF;
        t.dt = 20'hFFFFF;
        t.r_even = 17'h1FFFF;
        t.r_odd = 17'h1FFFF;
        t.h = 17'sh0FFFF;
        add_row(t, 0, '0);
        t.yaw = 32'sh7FFFFFFF;
        t.rate = 32'sh80000000;
        t.vz = 32'sh80000000;
        add_row(t, 0, '0);
        t = '0;
        t.yaw = 32'sd102944;
        t.r_even = 17'd40000;
        t.r_odd = 17'd50000;
        t.h = 17'sd3000;
        add_row(t, 0, '0);
        t.yaw = 32'sd308831;
        add_row(t, 0, '0);
        t.yaw = -32'sd411775;
        t.dt = 20'd65536;
        t.rate = 32'sd205887;
        add_row(t, 0, '0);
        for (int k = 0; k < 5; k++) add_row(random_target(), 0, '0);

        foreach (rows[k]) begin
            if (rows[k].has_exp) begin
                e = rows[k].exp0;
                e.last = (cur_count == 1);
                predict_panels(rows[k].tgt);
                if (expected_panels[expected_panels.size() - cur_count] !== e) begin
                    mismatches++;
                    $display("predictor disagrees with typed row %0d", k);
                end
                repeat (cur_count) void'(expected_panels.pop_back());
            end
            send_target(rows[k].tgt);
        end
        s_axis_tvalid <= 0;
        drain();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (1500) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 6; k++) send_target(random_target());
                s_axis_tvalid <= 0;
            end
        join
        drain();

        foreach (counts[c]) begin
            set_count(counts[c]);
            quiet = (c == 2);
            for (int k = 0; k < 22; k++) begin
                send_target(random_target());
                burst = $urandom_range(0, 3);
                if (burst == 0) begin
                    s_axis_tvalid <= 0;
                    repeat ($urandom_range(1, 60)) @(posedge i_clk);
                end
            end
            s_axis_tvalid <= 0;
            drain();
        end

        if (mismatches == 0 && expected_panels.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
